@@ src/tes_pkg.sv @@
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types and constants for the touch event to segment decoder: beat
// payloads, event codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package tes_pkg;

   // Default geometry
   localparam int SCREEN_WIDTH_DEF  = 1280;
   localparam int SCREEN_HEIGHT_DEF = 800;
   localparam int SLOT_COUNT_DEF    = 10;

   // Field widths of the beats
   localparam int EVT_TYPE_W  = 16;
   localparam int EVT_CODE_W  = 16;
   localparam int EVT_VALUE_W = 32;
   localparam int SLOT_IDX_W  = 4;
   localparam int PT_X_W      = 11;
   localparam int PT_Y_W      = 10;

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // Event classes and codes
   localparam logic [EVT_TYPE_W-1:0] EVT_SYN = 16'h0000;
   localparam logic [EVT_TYPE_W-1:0] EVT_KEY = 16'h0001;
   localparam logic [EVT_TYPE_W-1:0] EVT_ABS = 16'h0003;

   localparam logic [EVT_CODE_W-1:0] CODE_REPORT    = 16'h0000;
   localparam logic [EVT_CODE_W-1:0] CODE_DROPPED   = 16'h0003;
   localparam logic [EVT_CODE_W-1:0] CODE_ABS_X     = 16'h0000;
   localparam logic [EVT_CODE_W-1:0] CODE_ABS_Y     = 16'h0001;
   localparam logic [EVT_CODE_W-1:0] CODE_MT_SLOT   = 16'h002F;
   localparam logic [EVT_CODE_W-1:0] CODE_MT_X      = 16'h0035;
   localparam logic [EVT_CODE_W-1:0] CODE_MT_Y      = 16'h0036;
   localparam logic [EVT_CODE_W-1:0] CODE_MT_TRACK  = 16'h0039;
   localparam logic [EVT_CODE_W-1:0] CODE_TOUCH_KEY = 16'h014A;

   // Register reset values
   localparam logic signed [CSR_DATA_W-1:0] AXIS_MIN_RST = 32'sd0;
   localparam logic signed [CSR_DATA_W-1:0] AXIS_MAX_RST = 32'sd4095;

   typedef enum logic [2:0] {
      REG_MODE  = 3'd0,
      REG_X_MIN = 3'd1,
      REG_X_MAX = 3'd2,
      REG_Y_MIN = 3'd3,
      REG_Y_MAX = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [EVT_TYPE_W-1:0]         event_type;
      logic [EVT_CODE_W-1:0]         event_code;
      logic signed [EVT_VALUE_W-1:0] event_value;
   } req_type;

   typedef struct packed {
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [PT_X_W-1:0]     from_x;
      logic [PT_Y_W-1:0]     from_y;
      logic [PT_X_W-1:0]     to_x;
      logic [PT_Y_W-1:0]     to_y;
      logic                  last_in_report;
   } rsp_type;

endpackage

@@ src/touch_event_to_segments.sv @@
// ----------------------------------------------------------------------------
// touch_event_to_segments
// Decodes Linux input events (multitouch protocol B, or single touch on slot
// zero) into screen line segments, one per moved contact on each report.
// ----------------------------------------------------------------------------
// Every event other than a sync report is applied when it is taken. A report
// walks the slots in ascending order through one shared multiply and restoring
// divide unit: an idle slot passes through the scan state only, a moved active
// slot through scan, then multiply, check and divide for each axis, then emit.
// QB = clog2(max(SCREEN_WIDTH, SCREEN_HEIGHT)) is the number of quotient bits
// the divider produces one per cycle for each axis (a coordinate that clamps
// skips its divide); the input is freed once the walk has passed the last
// slot. The sequencer stalls on a segment only while the output register still
// holds an untaken one. No memory clearing pass after reset.
// ----------------------------------------------------------------------------
module touch_event_to_segments #(
   parameter int SCREEN_WIDTH  = tes_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tes_pkg::SCREEN_HEIGHT_DEF,
   parameter int SLOT_COUNT    = tes_pkg::SLOT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // event input
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tes_pkg::req_type                req_payload,
   // segment output
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tes_pkg::rsp_type                rsp_payload,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tes_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tes_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tes_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int SLW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SMAX   = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int QB     = $clog2(SMAX);
   localparam int PW     = 34 + QB;
   localparam int NUM_W  = 36 + QB;
   localparam int STW    = (QB > 1) ? $clog2(QB) : 1;
   localparam logic [SLW-1:0] SLOT_LAST = SLW'(SLOT_COUNT - 1);
   localparam logic signed [31:0] SLOT_LAST_V = 32'(SLOT_COUNT - 1);
   localparam logic [QB-1:0] X_PT_MAX = QB'(SCREEN_WIDTH - 1);
   localparam logic [QB-1:0] Y_PT_MAX = QB'(SCREEN_HEIGHT - 1);

   // ---------------------------------------------------------------- state
   tes_pkg::state_type state_ff, state_in;

   logic                  mode_ff;
   logic signed [31:0]    x_min_ff, x_max_ff, y_min_ff, y_max_ff;

   logic [SLOT_COUNT-1:0] active_ff, moved_ff, trail_ff;
   logic signed [31:0]    raw_x_ff [SLOT_COUNT];
   logic signed [31:0]    raw_y_ff [SLOT_COUNT];
   logic [tes_pkg::PT_X_W-1:0] last_x_ff [SLOT_COUNT];
   logic [tes_pkg::PT_Y_W-1:0] last_y_ff [SLOT_COUNT];
   logic [SLW-1:0]        cur_slot_ff;
   logic                  resync_ff;

   logic [SLW-1:0]        idx_ff;
   logic                  axis_ff;
   logic [NUM_W-1:0]      rem_ff, den_ff, dsh_ff;
   logic [STW-1:0]        step_ff;
   logic [QB-1:0]         q_ff, px_ff, py_ff;

   logic                  rsp_valid_ff;
   tes_pkg::rsp_type      rsp_ff;

   // ---------------------------------------------------------------- decode
   logic req_fire, csr_wr, is_report;
   logic [tes_pkg::EVT_TYPE_W-1:0] ev_type;
   logic [tes_pkg::EVT_CODE_W-1:0] ev_code;
   logic signed [31:0]             ev_value;
   logic [SLW-1:0]                 slot_sat;

   assign pready    = 1'b1;
   assign req_ready = (state_ff == tes_pkg::ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign csr_wr    = psel & penable & pwrite & pready;
   assign ev_type   = req_payload.event_type;
   assign ev_code   = req_payload.event_code;
   assign ev_value  = req_payload.event_value;
   assign is_report = (ev_type == tes_pkg::EVT_SYN) && (ev_code == tes_pkg::CODE_REPORT);

   // slot number saturated to the slot range
   always_comb begin
      priority if (ev_value[31]) begin
         slot_sat = '0;
      end else if (ev_value > SLOT_LAST_V) begin
         slot_sat = SLOT_LAST;
      end else begin
         slot_sat = ev_value[SLW-1:0];
      end
   end

   // ---------------------------------------------------------------- scaling unit
   logic signed [31:0]    sel_v, sel_lo, sel_hi;
   logic [QB-1:0]         sel_pmax;
   logic signed [32:0]    d_c, span_raw;
   logic [32:0]           span_c;
   logic signed [PW-1:0]  prod_c;
   logic [NUM_W-1:0]      num_c, den_c;
   logic                  neg_c, ovf_c, ge_c;
   logic [QB:0]           q_full;
   logic [QB-1:0]         q_fin;

   assign sel_v    = axis_ff ? raw_y_ff[idx_ff] : raw_x_ff[idx_ff];
   assign sel_lo   = axis_ff ? y_min_ff : x_min_ff;
   assign sel_hi   = axis_ff ? y_max_ff : x_max_ff;
   assign sel_pmax = axis_ff ? Y_PT_MAX : X_PT_MAX;

   assign d_c      = {sel_v[31], sel_v} - {sel_lo[31], sel_lo};
   assign span_raw = {sel_hi[31], sel_hi} - {sel_lo[31], sel_lo};
   // degenerate range counts as span one
   assign span_c   = (span_raw[32] || (span_raw == 33'sd0)) ? 33'd1 : span_raw;
   assign prod_c   = d_c * $signed({1'b0, sel_pmax});
   assign num_c    = {prod_c[PW-1], prod_c, 1'b0} + NUM_W'(span_c);
   assign den_c    = NUM_W'({span_c, 1'b0});

   assign neg_c  = rem_ff[NUM_W-1];
   assign ovf_c  = rem_ff >= (den_ff << QB);
   assign ge_c   = rem_ff >= dsh_ff;
   assign q_full = {q_ff, ge_c};
   assign q_fin  = (q_full > {1'b0, sel_pmax}) ? sel_pmax : q_full[QB-1:0];

   // ---------------------------------------------------------------- report scan
   logic [SLOT_COUNT-1:0] pend, above;
   logic                  last_c, emit_go, idx_last;

   assign pend = active_ff & moved_ff;
   always_comb begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
         above[j] = (SLW'(j) > idx_ff);
      end
   end
   assign last_c   = ~|(pend & above);
   assign idx_last = (idx_ff == SLOT_LAST);
   assign emit_go  = (state_ff == tes_pkg::ST_EMIT) & (~rsp_valid_ff | rsp_ready);

   // ---------------------------------------------------------------- sequencer
   logic          fin;
   logic [QB-1:0] fin_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tes_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      fin      = 1'b0;
      fin_val  = q_fin;
      unique case (state_ff)
         tes_pkg::ST_IDLE: begin
            if (req_fire && is_report && !resync_ff) state_in = tes_pkg::ST_SCAN;
         end
         tes_pkg::ST_SCAN: begin
            priority if (pend[idx_ff]) begin
               state_in = tes_pkg::ST_MUL;
            end else if (idx_last) begin
               state_in = tes_pkg::ST_IDLE;
            end else begin
               state_in = tes_pkg::ST_SCAN;
            end
         end
         tes_pkg::ST_MUL: begin
            state_in = tes_pkg::ST_CHECK;
         end
         tes_pkg::ST_CHECK: begin
            // negative numerator gives zero, a huge quotient the far edge
            priority if (neg_c) begin
               fin     = 1'b1;
               fin_val = '0;
            end else if (ovf_c) begin
               fin     = 1'b1;
               fin_val = sel_pmax;
            end else begin
               state_in = tes_pkg::ST_DIV;
            end
            if (fin) state_in = axis_ff ? tes_pkg::ST_EMIT : tes_pkg::ST_MUL;
         end
         tes_pkg::ST_DIV: begin
            if (step_ff == '0) begin
               fin      = 1'b1;
               state_in = axis_ff ? tes_pkg::ST_EMIT : tes_pkg::ST_MUL;
            end
         end
         tes_pkg::ST_EMIT: begin
            if (emit_go) state_in = idx_last ? tes_pkg::ST_IDLE : tes_pkg::ST_SCAN;
         end
         default: begin
            state_in = tes_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         axis_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            tes_pkg::ST_IDLE: begin
               idx_ff  <= '0;
               axis_ff <= 1'b0;
            end
            tes_pkg::ST_SCAN: begin
               axis_ff <= 1'b0;
               if (!pend[idx_ff] && !idx_last) idx_ff <= idx_ff + 1'b1;
            end
            tes_pkg::ST_MUL: begin
               rem_ff <= num_c;
               den_ff <= den_c;
            end
            tes_pkg::ST_CHECK: begin
               dsh_ff  <= den_ff << (QB - 1);
               step_ff <= STW'(QB - 1);
               q_ff    <= '0;
            end
            tes_pkg::ST_DIV: begin
               if (ge_c) rem_ff <= rem_ff - dsh_ff;
               dsh_ff  <= dsh_ff >> 1;
               q_ff    <= q_full[QB-1:0];
               step_ff <= step_ff - 1'b1;
            end
            tes_pkg::ST_EMIT: begin
               if (emit_go && !idx_last) idx_ff <= idx_ff + 1'b1;
            end
            default: begin
            end
         endcase
         // finished coordinate
         if (fin) begin
            if (axis_ff) begin
               py_ff <= fin_val;
            end else begin
               px_ff   <= fin_val;
               axis_ff <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------- contact state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= '0;
         moved_ff    <= '0;
         trail_ff    <= '0;
         cur_slot_ff <= '0;
         resync_ff   <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            raw_x_ff[i] <= '0;
            raw_y_ff[i] <= '0;
         end
      end else if (req_fire) begin
         priority if (resync_ff) begin
            // skip everything until the next report
            if (is_report) begin
               resync_ff <= 1'b0;
               trail_ff  <= '0;
            end
         end else if (ev_type == tes_pkg::EVT_ABS) begin
            if (mode_ff) begin
               priority if (ev_code == tes_pkg::CODE_MT_SLOT) begin
                  cur_slot_ff <= slot_sat;
               end else if (ev_code == tes_pkg::CODE_MT_TRACK) begin
                  active_ff[cur_slot_ff] <= ~ev_value[31];
                  trail_ff[cur_slot_ff]  <= 1'b0;
               end else if (ev_code == tes_pkg::CODE_MT_X) begin
                  raw_x_ff[cur_slot_ff] <= ev_value;
                  moved_ff[cur_slot_ff] <= 1'b1;
               end else if (ev_code == tes_pkg::CODE_MT_Y) begin
                  raw_y_ff[cur_slot_ff] <= ev_value;
                  moved_ff[cur_slot_ff] <= 1'b1;
               end
            end else begin
               priority if (ev_code == tes_pkg::CODE_ABS_X) begin
                  raw_x_ff[0] <= ev_value;
                  moved_ff[0] <= 1'b1;
               end else if (ev_code == tes_pkg::CODE_ABS_Y) begin
                  raw_y_ff[0] <= ev_value;
                  moved_ff[0] <= 1'b1;
               end
            end
         end else if (ev_type == tes_pkg::EVT_KEY) begin
            if (!mode_ff && (ev_code == tes_pkg::CODE_TOUCH_KEY)) begin
               active_ff[0] <= (ev_value != 32'sd0);
               trail_ff[0]  <= 1'b0;
            end
         end else if (ev_type == tes_pkg::EVT_SYN) begin
            if (ev_code == tes_pkg::CODE_DROPPED) resync_ff <= 1'b1;
         end
      end else if (emit_go) begin
         moved_ff[idx_ff] <= 1'b0;
         trail_ff[idx_ff] <= 1'b1;
      end
   end

   // last screen point per slot, read only behind the trail flag
   always_ff @(posedge clock) begin
      if (emit_go) begin
         last_x_ff[idx_ff] <= tes_pkg::PT_X_W'(px_ff);
         last_y_ff[idx_ff] <= tes_pkg::PT_Y_W'(py_ff);
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_ff.slot_index     <= tes_pkg::SLOT_IDX_W'(idx_ff);
         rsp_ff.from_x         <= trail_ff[idx_ff] ? last_x_ff[idx_ff]
                                                   : tes_pkg::PT_X_W'(px_ff);
         rsp_ff.from_y         <= trail_ff[idx_ff] ? last_y_ff[idx_ff]
                                                   : tes_pkg::PT_Y_W'(py_ff);
         rsp_ff.to_x           <= tes_pkg::PT_X_W'(px_ff);
         rsp_ff.to_y           <= tes_pkg::PT_Y_W'(py_ff);
         rsp_ff.last_in_report <= last_c;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b1;
         x_min_ff <= tes_pkg::AXIS_MIN_RST;
         x_max_ff <= tes_pkg::AXIS_MAX_RST;
         y_min_ff <= tes_pkg::AXIS_MIN_RST;
         y_max_ff <= tes_pkg::AXIS_MAX_RST;
      end else if (csr_wr) begin
         unique case (tes_pkg::reg_index_type'(paddr[4:2]))
            tes_pkg::REG_MODE:  mode_ff  <= pwdata[0];
            tes_pkg::REG_X_MIN: x_min_ff <= pwdata;
            tes_pkg::REG_X_MAX: x_max_ff <= pwdata;
            tes_pkg::REG_Y_MIN: y_min_ff <= pwdata;
            tes_pkg::REG_Y_MAX: y_max_ff <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (tes_pkg::reg_index_type'(paddr[4:2]))
         tes_pkg::REG_MODE:  prdata = {31'd0, mode_ff};
         tes_pkg::REG_X_MIN: prdata = x_min_ff;
         tes_pkg::REG_X_MAX: prdata = x_max_ff;
         tes_pkg::REG_Y_MIN: prdata = y_min_ff;
         tes_pkg::REG_Y_MAX: prdata = y_max_ff;
         default:            prdata = '0;
      endcase
   end

endmodule
